[rtl/tbfrgb_pkg.sv]
// ----------------------------------------------------------------------------
// tbfrgb_pkg
// Shared types, constants and the square-root step function of the two-band RGB stretch.
// ----------------------------------------------------------------------------
package tbfrgb_pkg;

	localparam int NUM_STAGES = 114;

	localparam logic [2:0] CFG_USE_ARITH_MEAN = 3'd0;
	localparam logic [2:0] CFG_USE_ASINH      = 3'd1;
	localparam logic [2:0] CFG_COLOR_CORR     = 3'd2;
	localparam logic [2:0] CFG_GREEN_GAIN     = 3'd3;
	localparam logic [2:0] CFG_AMP            = 3'd4;

	localparam logic [15:0] COLOR_CORR_RST = 16'd4096;
	localparam logic [15:0] GREEN_GAIN_RST = 16'd4096;
	localparam logic [31:0] AMP_RST        = 32'd2097152;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [31:0] LN2_Q32  = 32'hB17217F8;
	localparam logic [54:0] SAT_A_Q  = 55'd393216;
	localparam logic [54:0] SAT_R_Q  = 55'd196608;
	localparam logic [17:0] RECIP3   = 18'd174763;

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0]       r;
		logic [31:0]       b;
		logic [31:0]       avg;
		logic [63:0]       rem_a;
		logic [31:0]       root_a;
		logic [63:0]       rem_b;
		logic [31:0]       root_b;
		logic [2:0][35:0]  ch;
		logic [35:0]       m;
		logic [37:0]       s;
		logic              zero;
		logic [53:0]       ph;
		logic [53:0]       pl;
		logic [54:0]       q;
		logic [16:0]       x;
		logic              sat_a;
		logic              sat_r;
		logic [30:0]       xq;
		logic [30:0]       y;
		logic [30:0]       lg;
		logic [16:0]       fa;
		logic [16:0]       f;
		logic [52:0]       fm;
		logic [2:0][52:0]  fc;
		logic [2:0][63:0]  n;
		logic [63:0]       d;
		logic [2:0][7:0]   quo;
	} pipe_t;

	// One digit of the restoring square root, producing root bit j.
	function automatic sq_t sqrt_step(input sq_t a, input int j);
		sq_t         o;
		logic [63:0] t;
		o = a;
		t = ({32'b0, a.root} << (j + 1)) | (64'd1 << (2 * j));
		if (a.rem >= t) begin
			o.rem  = a.rem - t;
			o.root = a.root | (32'd1 << j);
		end
		return o;
	endfunction

endpackage

[rtl/two_band_flux_to_rgb_stretch.sv]
// ----------------------------------------------------------------------------
// two_band_flux_to_rgb_stretch
// Per-pixel asinh or fourth-root color stretch from red and blue flux.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while the spare output entry is empty
// (in_ready) and delivers one RGB result per pixel in order. The pipeline
// depth is set by the digit-by-digit square roots (one root bit per stage),
// the bit-serial binary logarithm of the asinh stretch (one bit per stage) and
// the final restoring division (one quotient bit per stage). An output
// register with one spare entry decouples the pipeline from the consumer.
// Configuration writes are taken at any time but must only be issued while no
// transaction is in flight.
module two_band_flux_to_rgb_stretch
	import tbfrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] red_flux,
	input  logic [31:0] blue_flux,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);

	logic        use_arith_q;
	logic        use_asinh_q;
	logic [15:0] color_corr_q;
	logic [15:0] green_gain_q;
	logic [31:0] amp_q;

	pipe_t pipe_s [0:NUM_STAGES];
	pipe_t pipe_nx [1:NUM_STAGES];
	logic  vld_s [0:NUM_STAGES];
	logic  en;

	logic            out_v_q;
	logic            spare_v_q;
	logic [2:0][7:0] out_q;
	logic [2:0][7:0] spare_q;
	logic [2:0][7:0] res;
	logic            push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_arith_q  <= 1'b0;
			use_asinh_q  <= 1'b0;
			color_corr_q <= COLOR_CORR_RST;
			green_gain_q <= GREEN_GAIN_RST;
			amp_q        <= AMP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_USE_ARITH_MEAN: use_arith_q  <= cfg_data[0];
				CFG_USE_ASINH:      use_asinh_q  <= cfg_data[0];
				CFG_COLOR_CORR:     color_corr_q <= cfg_data[15:0];
				CFG_GREEN_GAIN:     green_gain_q <= cfg_data[15:0];
				CFG_AMP:            amp_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !spare_v_q;
	assign in_ready = en;
	assign pipe_s[0] = '0;
	assign vld_s[0]  = in_valid;

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_stage
		always_comb begin
			sq_t         sa;
			sq_t         sb;
			logic [31:0] g;
			logic [47:0] gp;
			logic [47:0] bp;
			logic [35:0] mm;
			logic [36:0] xp;
			logic [32:0] ysum;
			logic [61:0] ysq;
			logic [31:0] yn;
			logic [62:0] lp;
			logic [54:0] fm3;
			logic [63:0] t;
			pipe_nx[k] = pipe_s[k-1];
			sa.rem  = pipe_s[k-1].rem_a;
			sa.root = pipe_s[k-1].root_a;
			sb.rem  = pipe_s[k-1].rem_b;
			sb.root = pipe_s[k-1].root_b;
			g    = '0;
			gp   = '0;
			bp   = '0;
			mm   = '0;
			xp   = '0;
			ysum = '0;
			ysq  = '0;
			yn   = '0;
			lp   = '0;
			fm3  = '0;
			t    = '0;
			if (k == 1) begin
				pipe_nx[k].r      = red_flux;
				pipe_nx[k].b      = blue_flux;
				pipe_nx[k].avg    = 32'((33'(red_flux) + 33'(blue_flux)) >> 1);
				pipe_nx[k].rem_a  = 64'(red_flux) * 64'(blue_flux);
				pipe_nx[k].root_a = '0;
			end
			if (k >= 2 && k <= 33) begin
				sa = sqrt_step(sa, 33 - k);
				pipe_nx[k].rem_a  = sa.rem;
				pipe_nx[k].root_a = sa.root;
			end
			if (k == 34) begin
				g  = use_arith_q ? pipe_s[k-1].avg : pipe_s[k-1].root_a;
				gp = 48'(g) * 48'(green_gain_q);
				bp = 48'(pipe_s[k-1].b) * 48'(color_corr_q);
				pipe_nx[k].ch[0] = 36'(pipe_s[k-1].r);
				pipe_nx[k].ch[1] = gp[47:12];
				pipe_nx[k].ch[2] = bp[47:12];
			end
			if (k == 35) begin
				mm = pipe_s[k-1].ch[0];
				if (pipe_s[k-1].ch[1] > mm) begin
					mm = pipe_s[k-1].ch[1];
				end
				if (pipe_s[k-1].ch[2] > mm) begin
					mm = pipe_s[k-1].ch[2];
				end
				pipe_nx[k].m = mm;
				pipe_nx[k].s = 38'(pipe_s[k-1].ch[0]) + 38'(pipe_s[k-1].ch[1])
					+ 38'(pipe_s[k-1].ch[2]);
			end
			if (k == 36) begin
				pipe_nx[k].zero = (pipe_s[k-1].s == '0);
				pipe_nx[k].ph   = 54'(pipe_s[k-1].s) * 54'(amp_q[31:16]);
				pipe_nx[k].pl   = 54'(pipe_s[k-1].s) * 54'(amp_q[15:0]);
			end
			if (k == 37) begin
				pipe_nx[k].q = 55'(pipe_s[k-1].ph) + 55'(pipe_s[k-1].pl[53:16]);
			end
			if (k == 38) begin
				xp = 37'(pipe_s[k-1].q[18:0]) * 37'(RECIP3);
				pipe_nx[k].x     = xp[35:19];
				pipe_nx[k].sat_a = (pipe_s[k-1].q >= SAT_A_Q);
				pipe_nx[k].sat_r = (pipe_s[k-1].q >= SAT_R_Q);
			end
			if (k == 39) begin
				pipe_nx[k].xq     = {pipe_s[k-1].x, 14'b0};
				pipe_nx[k].rem_a  = 64'({pipe_s[k-1].x, 14'b0}) * 64'({pipe_s[k-1].x, 14'b0})
					+ (64'd1 << 60);
				pipe_nx[k].root_a = '0;
				pipe_nx[k].rem_b  = {pipe_s[k-1].x[15:0], 48'b0};
				pipe_nx[k].root_b = '0;
			end
			if (k >= 40 && k <= 71) begin
				sa = sqrt_step(sa, 71 - k);
				sb = sqrt_step(sb, 71 - k);
				pipe_nx[k].rem_a  = sa.rem;
				pipe_nx[k].root_a = sa.root;
				pipe_nx[k].rem_b  = sb.rem;
				pipe_nx[k].root_b = sb.root;
			end
			if (k == 72) begin
				ysum = 33'(pipe_s[k-1].xq) + 33'(pipe_s[k-1].root_a);
				if (ysum[31]) begin
					pipe_nx[k].y  = ysum[31:1];
					pipe_nx[k].lg = {1'b1, 30'b0};
				end else begin
					pipe_nx[k].y  = ysum[30:0];
					pipe_nx[k].lg = '0;
				end
				if (ysum[32]) begin
					pipe_nx[k].sat_a = 1'b1;
				end
				pipe_nx[k].rem_b  = {32'b0, pipe_s[k-1].root_b};
				pipe_nx[k].root_b = '0;
			end
			if (k >= 73 && k <= 88) begin
				sb = sqrt_step(sb, 88 - k);
				pipe_nx[k].rem_b  = sb.rem;
				pipe_nx[k].root_b = sb.root;
			end
			if (k >= 73 && k <= 102) begin
				ysq = 62'(pipe_s[k-1].y) * 62'(pipe_s[k-1].y);
				yn  = ysq[61:30];
				if (yn[31]) begin
					pipe_nx[k].y  = yn[31:1];
					pipe_nx[k].lg = pipe_s[k-1].lg | (31'd1 << (102 - k));
				end else begin
					pipe_nx[k].y = yn[30:0];
				end
			end
			if (k == 103) begin
				lp = 63'(pipe_s[k-1].lg) * 63'(LN2_Q32);
				pipe_nx[k].fa = lp[62:46];
			end
			if (k == 104) begin
				if (use_asinh_q) begin
					if (pipe_s[k-1].sat_a || pipe_s[k-1].fa > ONE_Q16) begin
						pipe_nx[k].f = ONE_Q16;
					end else begin
						pipe_nx[k].f = pipe_s[k-1].fa;
					end
				end else if (pipe_s[k-1].sat_r) begin
					pipe_nx[k].f = ONE_Q16;
				end else begin
					pipe_nx[k].f = {1'b0, pipe_s[k-1].root_b[15:0]};
				end
			end
			if (k == 105) begin
				pipe_nx[k].fm = 53'(pipe_s[k-1].f) * 53'(pipe_s[k-1].m);
				for (int c = 0; c < 3; c++) begin
					pipe_nx[k].fc[c] = 53'(pipe_s[k-1].f) * 53'(pipe_s[k-1].ch[c]);
				end
			end
			if (k == 106) begin
				fm3 = 55'(pipe_s[k-1].fm) * 55'd3;
				pipe_nx[k].quo = '0;
				if (fm3 > 55'({pipe_s[k-1].s, 16'b0})) begin
					pipe_nx[k].d = 64'(pipe_s[k-1].m);
					for (int c = 0; c < 3; c++) begin
						pipe_nx[k].n[c] = 64'(pipe_s[k-1].ch[c]) * 64'd255;
					end
				end else begin
					pipe_nx[k].d = 64'({pipe_s[k-1].s, 16'b0});
					for (int c = 0; c < 3; c++) begin
						pipe_nx[k].n[c] = 64'(pipe_s[k-1].fc[c]) * 64'd765;
					end
				end
			end
			if (k >= 107 && k <= 114) begin
				t = pipe_s[k-1].d << (114 - k);
				for (int c = 0; c < 3; c++) begin
					if (pipe_s[k-1].n[c] >= t) begin
						pipe_nx[k].n[c]            = pipe_s[k-1].n[c] - t;
						pipe_nx[k].quo[c][114 - k] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= pipe_nx[k];
			end
		end
	end

	assign res  = pipe_s[NUM_STAGES].zero ? '0 : pipe_s[NUM_STAGES].quo;
	assign push = en && vld_s[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (spare_v_q) begin
			if (out_ready) begin
				spare_v_q <= 1'b0;
			end
		end else if (!out_v_q || out_ready) begin
			out_v_q <= push;
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (out_ready) begin
				out_q <= spare_q;
			end
		end else if (!out_v_q || out_ready) begin
			out_q <= res;
		end else if (push) begin
			spare_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign red_out   = out_q[0];
	assign green_out = out_q[1];
	assign blue_out  = out_q[2];

endmodule

[dv/tb_two_band_flux_to_rgb_stretch.sv]
// ----------------------------------------------------------------------------
// tb_two_band_flux_to_rgb_stretch
// Self-checking bench for the two-band flux to RGB display stretch.
// A directed table covers field extremes, both green means, both stretches,
// zero intensity and strong stretch; zero amplification follows. Random pixels
// then run under several register settings with random idling on both sides.
// Each display triple is checked against its typed row or a bit-exact model.
// ----------------------------------------------------------------------------
module tb_two_band_flux_to_rgb_stretch
	import tbfrgb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [31:0] red;
		logic [31:0] blue;
		bit          known;
		logic [7:0]  r_exp;
		logic [7:0]  g_exp;
		logic [7:0]  b_exp;
	} pixel_row_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] red_flux;
	logic [31:0] blue_flux;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;

	bit          arith_mean_sel;
	bit          asinh_sel;
	logic [15:0] blue_gain;
	logic [15:0] green_scale;
	logic [31:0] amplification;

	rgb_t        pending_rgb[$];
	int          mismatches;
	int          pixels_sent;
	int          pixels_checked;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off_cycles;

	two_band_flux_to_rgb_stretch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_flux  (red_flux),
		.blue_flux (blue_flux),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] asinh_fixed(input logic [63:0] x16);
		logic [63:0] xq;
		logic [63:0] y;
		logic [63:0] lg;
		logic [63:0] prod;
		xq = x16 << 14;
		y = xq + int_sqrt(xq * xq + (64'd1 << 60));
		lg = 0;
		while (y >= (64'd1 << 31)) begin
			y = y >> 1;
			lg = lg + (64'd1 << 30);
		end
		for (int i = 29; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				lg[i] = 1'b1;
			end
		end
		prod = (lg * 64'hB17217F8) >> 32;
		return prod >> 14;
	endfunction

	function automatic rgb_t stretch_pixel(input logic [31:0] red, input logic [31:0] blue);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] g;
		logic [63:0] s;
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] f;
		logic [63:0] m;
		logic [63:0] sh;
		logic [63:0] v;
		logic [63:0] ch[3];
		logic [7:0]  res[3];
		rgb_t        o;
		r = red;
		b = blue;
		g = arith_mean_sel ? (r + b) >> 1 : int_sqrt(r * b);
		ch[0] = r;
		ch[1] = (g * green_scale) >> 12;
		ch[2] = (b * blue_gain) >> 12;
		s = ch[0] + ch[1] + ch[2];
		if (s == 0) begin
			o.r = 0;
			o.g = 0;
			o.b = 0;
			return o;
		end
		q = s * amplification[31:16] + ((s * amplification[15:0]) >> 16);
		x = q / 3;
		if (asinh_sel)
			f = (x >= 131072) ? 65536 : asinh_fixed(x);
		else
			f = (x >= 65536) ? 65536 : int_sqrt(int_sqrt(x << 48));
		if (f > 65536)
			f = 65536;
		m = ch[0];
		if (ch[1] > m)
			m = ch[1];
		if (ch[2] > m)
			m = ch[2];
		sh = s << 16;
		for (int k = 0; k < 3; k++) begin
			if (3 * f * m > sh)
				v = (255 * ch[k]) / m;
			else
				v = (765 * f * ch[k]) / sh;
			res[k] = (v > 255) ? 8'd255 : v[7:0];
		end
		o.r = res[0];
		o.g = res[1];
		o.b = res[2];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch on %s at pixel %0d: got %0d, expected %0d", what,
			pixels_checked, got, want);
		mismatches++;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_USE_ARITH_MEAN: arith_mean_sel = value[0];
			CFG_USE_ASINH:      asinh_sel = value[0];
			CFG_COLOR_CORR:     blue_gain = value[15:0];
			CFG_GREEN_GAIN:     green_scale = value[15:0];
			CFG_AMP:            amplification = value;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [31:0] red, input logic [31:0] blue,
			input bit known, input rgb_t typed);
		rgb_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		predicted = stretch_pixel(red, blue);
		if (known && predicted != typed)
			$display("note: typed row disagrees with model for %h %h", red, blue);
		in_valid <= 1'b1;
		red_flux <= red;
		blue_flux <= blue;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_rgb.push_back(known ? typed : predicted);
		pixels_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (NUM_STAGES + 10)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_flux();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(255);
			2: return $urandom_range(32'h0003_0000);
			3: return 32'hFFFF_FFFF - $urandom_range(1000);
			default: return $urandom_range(32'h0010_0000);
		endcase
	endfunction

	task automatic random_pixels(input int count);
		rgb_t none;
		none = '{default: 0};
		for (int i = 0; i < count; i++)
			send_pixel(random_flux(), random_flux(), 1'b0, none);
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rgb.size() == 0) begin
				$display("unexpected result transaction %0d %0d %0d", red_out,
					green_out, blue_out);
				mismatches++;
			end else begin
				want = pending_rgb.pop_front();
				if (red_out !== want.r)
					report_mismatch("red", red_out, want.r);
				if (green_out !== want.g)
					report_mismatch("green", green_out, want.g);
				if (blue_out !== want.b)
					report_mismatch("blue", blue_out, want.b);
			end
			pixels_checked++;
		end
	end

	initial begin
		#4ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		pixel_row_t directed[$];
		rgb_t       typed;
		directed = '{
			'{32'h0, 32'h0, 1, 8'd0, 8'd0, 8'd0},
			'{32'h0001_0000, 32'h0, 1, 8'd255, 8'd0, 8'd0},
			'{32'h0, 32'h0001_0000, 1, 8'd0, 8'd0, 8'd255},
			'{32'h0001_0000, 32'h0001_0000, 1, 8'd255, 8'd255, 8'd255},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 8'd255, 8'd255, 8'd255},
			'{32'hFFFF_FFFF, 32'h0, 1, 8'd255, 8'd0, 8'd0},
			'{32'h0, 32'hFFFF_FFFF, 1, 8'd0, 8'd0, 8'd255},
			'{32'h1, 32'h0, 0, 0, 0, 0},
			'{32'h1, 32'h1, 0, 0, 0, 0},
			'{32'h0000_0100, 32'h0000_0040, 0, 0, 0, 0},
			'{32'h0000_1000, 32'h0002_0000, 0, 0, 0, 0},
			'{32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0},
			'{32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0}
		};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		red_flux = '0;
		blue_flux = '0;
		out_ready = 1'b0;
		arith_mean_sel = 0;
		asinh_sel = 0;
		blue_gain = COLOR_CORR_RST;
		green_scale = GREEN_GAIN_RST;
		amplification = AMP_RST;
		mismatches = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		send_idle_pct = 21;
		recv_idle_pct = 45;
		hold_off_cycles = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int pass = 0; pass < 2; pass++) begin
			foreach (directed[i]) begin
				typed.r = directed[i].r_exp;
				typed.g = directed[i].g_exp;
				typed.b = directed[i].b_exp;
				send_pixel(directed[i].red, directed[i].blue,
					directed[i].known && pass == 0, typed);
			end
			drain_pipeline();
			write_register(CFG_USE_ASINH, 32'd1);
			write_register(CFG_USE_ARITH_MEAN, 32'd1);
		end
		write_register(CFG_AMP, 32'd0);
		send_pixel(32'h0001_0000, 32'h0002_0000, 1'b1, '{8'd0, 8'd0, 8'd0});
		send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 1'b1, '{8'd0, 8'd0, 8'd0});
		drain_pipeline();
		write_register(CFG_UNUSED, 32'hFFFF_FFFF);

		// Long receiver hold-off so the pipeline fills and back-pressures.
		write_register(CFG_AMP, AMP_RST);
		hold_off_cycles = 300;
		send_idle_pct = 0;
		random_pixels(160);
		drain_pipeline();

		send_idle_pct = 45;
		recv_idle_pct = 21;
		for (int phase = 0; phase < 6; phase++) begin
			write_register(CFG_USE_ARITH_MEAN, $urandom_range(1));
			write_register(CFG_USE_ASINH, $urandom_range(1));
			case (phase)
				0: begin
					write_register(CFG_COLOR_CORR, 32'd0);
					write_register(CFG_GREEN_GAIN, 32'hFFFF);
					write_register(CFG_AMP, 32'hFFFF_FFFF);
				end
				1: begin
					write_register(CFG_COLOR_CORR, 32'hFFFF);
					write_register(CFG_GREEN_GAIN, 32'd0);
					write_register(CFG_AMP, 32'd1);
				end
				default: begin
					write_register(CFG_COLOR_CORR, $urandom_range(16'h3000));
					write_register(CFG_GREEN_GAIN, $urandom_range(16'h3000));
					write_register(CFG_AMP, $urandom_range(32'h0040_0000));
				end
			endcase
			if (phase == 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_pixels(65);
			drain_pipeline();
		end

		$display("covered %0d pixels, %0d results checked, over both means, both stretches",
			pixels_sent, pixels_checked);
		$display("and register extremes, with idling, a long output stall and drains");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
